/* rtl/tgr_pkg.sv */
package tgr_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int TIME_W      = 32;
    localparam int COUNT_W     = 8;
    localparam int DUR_W       = 16;

    // Register indexes on the configuration channel
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_CONFIRM = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TAP_MAX_DUR     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TAP_TOLERANCE   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_MS         = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SURFACE_WIDTH   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SURFACE_HEIGHT  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_ORIENTATION     = 3'd6;

    localparam logic [COUNT_W-1:0] RST_RELEASE_CONFIRM = 8'd2;
    localparam logic [DUR_W-1:0]   RST_TAP_MAX_DUR     = 16'd300;
    localparam logic [DUR_W-1:0]   RST_HOLD_MS         = 16'd600;
    localparam int                 RST_TAP_TOLERANCE   = 12;
    localparam int                 RST_SURFACE_WIDTH   = 320;
    localparam int                 RST_SURFACE_HEIGHT  = 480;

    typedef enum logic [1:0] {
        ORIENT_PORTRAIT       = 2'd0,
        ORIENT_LANDSCAPE      = 2'd1,
        ORIENT_PORTRAIT_FLIP  = 2'd2,
        ORIENT_LANDSCAPE_FLIP = 2'd3
    } orient_t;

    // Event kind flags, event_valid in the lowest bit
    typedef struct packed {
        logic is_tap;
        logic is_release;
        logic is_hold;
        logic is_move;
        logic is_start;
        logic event_valid;
    } evt_flags_t;

endpackage

/* rtl/tgr_orient.sv */
module tgr_orient #(
    parameter int COORD_BITS = 12
) (
    input  logic [COORD_BITS-1:0] raw_x,
    input  logic [COORD_BITS-1:0] raw_y,
    input  logic [COORD_BITS-1:0] surface_width,
    input  logic [COORD_BITS-1:0] surface_height,
    input  tgr_pkg::orient_t      orientation,
    output logic [COORD_BITS-1:0] ori_x,
    output logic [COORD_BITS-1:0] ori_y
);

    logic [COORD_BITS-1:0] max_x;
    logic [COORD_BITS-1:0] max_y;
    logic [COORD_BITS-1:0] clamp_x;
    logic [COORD_BITS-1:0] clamp_y;

    // A zero size behaves as a size of one, so the coordinate clamps to zero.
    assign max_x   = (surface_width  == '0) ? '0 : surface_width  - COORD_BITS'(1);
    assign max_y   = (surface_height == '0) ? '0 : surface_height - COORD_BITS'(1);
    assign clamp_x = (raw_x > max_x) ? max_x : raw_x;
    assign clamp_y = (raw_y > max_y) ? max_y : raw_y;

    always_comb begin
        case (orientation)
            tgr_pkg::ORIENT_PORTRAIT: begin
                ori_x = clamp_x;
                ori_y = clamp_y;
            end
            tgr_pkg::ORIENT_LANDSCAPE: begin
                ori_x = clamp_y;
                ori_y = max_x - clamp_x;
            end
            tgr_pkg::ORIENT_PORTRAIT_FLIP: begin
                ori_x = max_x - clamp_x;
                ori_y = max_y - clamp_y;
            end
            tgr_pkg::ORIENT_LANDSCAPE_FLIP: begin
                ori_x = max_y - clamp_y;
                ori_y = clamp_x;
            end
            default: begin
                ori_x = clamp_x;
                ori_y = clamp_y;
            end
        endcase
    end

endmodule

/* rtl/touch_gesture_recognizer_core.sv */
// Touch tap and hold gesture recogniser.
// The s_ channel takes one panel sample per word: touched in s_tuser, raw X, raw Y and a
// millisecond timestamp in s_tdata. The m_ channel returns exactly one word per sample:
// the event kind flags in m_tuser and the oriented position in m_tdata. A sample with no
// event still returns a word, with every field zero.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes the
// seven settings; it is always ready and should only be used while no sample is in
// flight.
// The sample waits in the input register; clamping, rotation and the gesture update are
// done on the way into the result register, which drives m_.
// The core takes one sample per cycle while the receiver keeps m_tready high, as the
// gesture state is updated once for each sample that moves into the result register.
// Reset (aresetn low at a clock edge) empties both stages, ends any gesture and restores
// the default settings. When the receiver stalls, the result word holds and the input
// register still takes one more sample; after that s_tready drops until m_tready returns.
module touch_gesture_recognizer_core #(
    parameter int COORD_BITS = 12
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // raw_x, raw_y, now_ms
    input  logic [((2*COORD_BITS+tgr_pkg::TIME_W+7)/8)*8-1:0] s_tdata,
    // touched
    input  logic                                  s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // event_x, event_y
    output logic [((2*COORD_BITS+7)/8)*8-1:0]     m_tdata,
    // event_valid, is_start, is_move, is_hold, is_release, is_tap
    output logic [5:0]                            m_tuser,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [tgr_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [tgr_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int M_DATA_W = ((2*COORD_BITS+7)/8)*8;
    localparam int S_USED_W = 2*COORD_BITS+tgr_pkg::TIME_W;

    // Settings
    logic [tgr_pkg::COUNT_W-1:0] release_confirm_reg;
    logic [tgr_pkg::DUR_W-1:0]   tap_max_dur_reg;
    logic [COORD_BITS-1:0]       tap_tol_reg;
    logic [tgr_pkg::DUR_W-1:0]   hold_ms_reg;
    logic [COORD_BITS-1:0]       surface_w_reg;
    logic [COORD_BITS-1:0]       surface_h_reg;
    tgr_pkg::orient_t            orient_reg;

    // Input stage
    logic                        s1_valid_reg;
    logic                        s1_touched_reg;
    logic [COORD_BITS-1:0]       s1_x_reg;
    logic [COORD_BITS-1:0]       s1_y_reg;
    logic [tgr_pkg::TIME_W-1:0]  s1_now_reg;
    logic [COORD_BITS-1:0]       ori_x;
    logic [COORD_BITS-1:0]       ori_y;
    logic [COORD_BITS-1:0]       raw_x;
    logic [COORD_BITS-1:0]       raw_y;
    logic [tgr_pkg::TIME_W-1:0]  now_ms;

    // Gesture state
    logic                        active_reg,   active_next;
    logic                        hold_rep_reg, hold_rep_next;
    logic [tgr_pkg::COUNT_W-1:0] empty_reg,    empty_next;
    logic [tgr_pkg::TIME_W-1:0]  press_t_reg,  press_t_next;
    logic [COORD_BITS-1:0]       press_x_reg,  press_x_next;
    logic [COORD_BITS-1:0]       press_y_reg,  press_y_next;
    logic [COORD_BITS-1:0]       last_x_reg,   last_x_next;
    logic [COORD_BITS-1:0]       last_y_reg,   last_y_next;

    // Result stage
    logic                        m_valid_reg;
    tgr_pkg::evt_flags_t         evt_reg,      evt_next;
    logic [COORD_BITS-1:0]       ev_x_reg,     ev_x_next;
    logic [COORD_BITS-1:0]       ev_y_reg,     ev_y_next;

    logic                        s_accept;
    logic                        adv;
    logic [tgr_pkg::TIME_W-1:0]  elapsed;
    logic [tgr_pkg::COUNT_W-1:0] empty_inc;
    logic [COORD_BITS-1:0]       cmp_x;
    logic [COORD_BITS-1:0]       cmp_y;
    logic [COORD_BITS-1:0]       diff_x;
    logic [COORD_BITS-1:0]       diff_y;
    logic                        within_tol;

    assign raw_x  = s_tdata[COORD_BITS-1:0];
    assign raw_y  = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign now_ms = s_tdata[S_USED_W-1:2*COORD_BITS];

    assign adv      = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || adv;
    assign s_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            release_confirm_reg <= tgr_pkg::RST_RELEASE_CONFIRM;
            tap_max_dur_reg     <= tgr_pkg::RST_TAP_MAX_DUR;
            tap_tol_reg         <= COORD_BITS'(tgr_pkg::RST_TAP_TOLERANCE);
            hold_ms_reg         <= tgr_pkg::RST_HOLD_MS;
            surface_w_reg       <= COORD_BITS'(tgr_pkg::RST_SURFACE_WIDTH);
            surface_h_reg       <= COORD_BITS'(tgr_pkg::RST_SURFACE_HEIGHT);
            orient_reg          <= tgr_pkg::ORIENT_PORTRAIT;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                tgr_pkg::REG_RELEASE_CONFIRM:
                    release_confirm_reg <= cfg_data[tgr_pkg::COUNT_W-1:0];
                tgr_pkg::REG_TAP_MAX_DUR:    tap_max_dur_reg <= cfg_data;
                tgr_pkg::REG_TAP_TOLERANCE:  tap_tol_reg <= cfg_data[COORD_BITS-1:0];
                tgr_pkg::REG_HOLD_MS:        hold_ms_reg <= cfg_data;
                tgr_pkg::REG_SURFACE_WIDTH:  surface_w_reg <= cfg_data[COORD_BITS-1:0];
                tgr_pkg::REG_SURFACE_HEIGHT: surface_h_reg <= cfg_data[COORD_BITS-1:0];
                tgr_pkg::REG_ORIENTATION:
                    orient_reg <= tgr_pkg::orient_t'(cfg_data[1:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_touched_reg <= s_tuser;
            s1_x_reg       <= raw_x;
            s1_y_reg       <= raw_y;
            s1_now_reg     <= now_ms;
        end
    end

    tgr_orient #(
        .COORD_BITS (COORD_BITS)
    ) u_orient (
        .raw_x          (s1_x_reg),
        .raw_y          (s1_y_reg),
        .surface_width  (surface_w_reg),
        .surface_height (surface_h_reg),
        .orientation    (orient_reg),
        .ori_x          (ori_x),
        .ori_y          (ori_y)
    );

    // The tolerance test compares against the new position on a move and against the
    // last position on a release.
    assign elapsed   = s1_now_reg - press_t_reg;
    assign empty_inc = empty_reg + tgr_pkg::COUNT_W'(1);
    assign cmp_x     = s1_touched_reg ? ori_x : last_x_reg;
    assign cmp_y     = s1_touched_reg ? ori_y : last_y_reg;
    assign diff_x    = (cmp_x > press_x_reg) ? cmp_x - press_x_reg : press_x_reg - cmp_x;
    assign diff_y    = (cmp_y > press_y_reg) ? cmp_y - press_y_reg : press_y_reg - cmp_y;
    assign within_tol = (diff_x <= tap_tol_reg) && (diff_y <= tap_tol_reg);

    always_comb begin
        active_next   = active_reg;
        hold_rep_next = hold_rep_reg;
        empty_next    = empty_reg;
        press_t_next  = press_t_reg;
        press_x_next  = press_x_reg;
        press_y_next  = press_y_reg;
        last_x_next   = last_x_reg;
        last_y_next   = last_y_reg;
        evt_next      = '0;
        ev_x_next     = '0;
        ev_y_next     = '0;
        if (!s1_touched_reg) begin
            if (active_reg) begin
                if (empty_inc < release_confirm_reg) begin
                    empty_next = empty_inc;
                end else begin
                    evt_next.event_valid = 1'b1;
                    evt_next.is_release  = 1'b1;
                    evt_next.is_tap      = (elapsed <= tgr_pkg::TIME_W'(tap_max_dur_reg))
                                           && within_tol;
                    ev_x_next   = last_x_reg;
                    ev_y_next   = last_y_reg;
                    active_next = 1'b0;
                    empty_next  = '0;
                end
            end
        end else begin
            empty_next           = '0;
            evt_next.event_valid = 1'b1;
            ev_x_next            = ori_x;
            ev_y_next            = ori_y;
            last_x_next          = ori_x;
            last_y_next          = ori_y;
            if (!active_reg) begin
                active_next       = 1'b1;
                hold_rep_next     = 1'b0;
                press_t_next      = s1_now_reg;
                press_x_next      = ori_x;
                press_y_next      = ori_y;
                evt_next.is_start = 1'b1;
            end else begin
                evt_next.is_move = 1'b1;
                if (!hold_rep_reg && (elapsed >= tgr_pkg::TIME_W'(hold_ms_reg))
                        && within_tol) begin
                    hold_rep_next    = 1'b1;
                    evt_next.is_hold = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= 1'b0;
            hold_rep_reg <= 1'b0;
            empty_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (adv) begin
                active_reg   <= active_next;
                hold_rep_reg <= hold_rep_next;
                empty_reg    <= empty_next;
            end
            if (adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            press_t_reg <= press_t_next;
            press_x_reg <= press_x_next;
            press_y_reg <= press_y_next;
            last_x_reg  <= last_x_next;
            last_y_reg  <= last_y_next;
            evt_reg     <= evt_next;
            ev_x_reg    <= ev_x_next;
            ev_y_reg    <= ev_y_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = evt_reg;
    assign m_tdata  = M_DATA_W'({ev_y_reg, ev_x_reg});

    // Exactly one of start, move and release is set whenever an event is reported, and none otherwise.
    a_kind_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (evt_reg.event_valid ==
            $onehot({evt_reg.is_start, evt_reg.is_move, evt_reg.is_release})))
        else $error("event kind flags inconsistent with event_valid");

    // A tap only comes with a release, a hold only with a move.
    a_tap_hold_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((!evt_reg.is_tap || evt_reg.is_release)
                         && (!evt_reg.is_hold || evt_reg.is_move)))
        else $error("tap or hold reported with the wrong event kind");

    // A release ends the gesture; a start opens one.
    a_release_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && evt_next.is_release |=> !active_reg && m_valid_reg)
        else $error("gesture still active after release");

    a_start_opens: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && evt_next.is_start |=> active_reg && !hold_rep_reg)
        else $error("gesture not opened on start");

endmodule

/* tb/touch_gesture_checker.sv */
`timescale 1ns / 1ps

module touch_gesture_checker
    import tgr_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  logic                                            s_tvalid,
    input  logic                                            s_tready,
    // raw_x, raw_y, now_ms
    input  logic [((2*COORD_BITS+TIME_W+7)/8)*8-1:0]        s_tdata,
    // touched
    input  logic                                            s_tuser,
    input  logic                                            m_tvalid,
    input  logic                                            m_tready,
    // event_x, event_y
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]               m_tdata,
    // event_valid, is_start, is_move, is_hold, is_release, is_tap
    input  logic [5:0]                                      m_tuser,
    input  logic                                            cfg_valid,
    input  logic                                            cfg_ready,
    input  logic [CFG_INDEX_W-1:0]                          cfg_index,
    input  logic [CFG_DATA_W-1:0]                           cfg_data,
    output int                                              error_count,
    output int                                              pending
);

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        evt_flags_t flags;
        coord_t     ex;
        coord_t     ey;
    } gesture_event_t;

    // Settings as last written on the configuration channel
    logic [7:0]  confirm_need;
    logic [15:0] tap_limit_ms;
    logic [11:0] move_tol;
    logic [15:0] hold_limit_ms;
    logic [11:0] width_px;
    logic [11:0] height_px;
    orient_t     view;

    // Gesture state
    logic        in_gesture;
    logic        hold_done;
    logic [7:0]  empty_run;
    logic [31:0] press_ms;
    coord_t      press_px, press_py;
    coord_t      last_px, last_py;

    gesture_event_t expected_events[$];
    gesture_event_t want, got;

    function automatic coord_t span(coord_t a, coord_t b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic logic still_near();
        return span(last_px, press_px) <= move_tol && span(last_py, press_py) <= move_tol;
    endfunction

    // Works out the event word for one sample and advances the gesture state.
    function automatic gesture_event_t next_event(logic touched, coord_t rx, coord_t ry,
                                                  logic [31:0] now);
        gesture_event_t w;
        logic [31:0]    elapsed;
        coord_t         lim_x, lim_y, cx, cy, ox, oy;
        w = '0;
        if (!touched) begin
            if (!in_gesture)
                return w;
            empty_run = empty_run + 8'd1;
            if (empty_run < confirm_need)
                return w;
            elapsed = now - press_ms;
            w.flags.event_valid = 1'b1;
            w.flags.is_release  = 1'b1;
            w.flags.is_tap      = (elapsed <= {16'd0, tap_limit_ms}) && still_near();
            w.ex = last_px;
            w.ey = last_py;
            in_gesture = 1'b0;
            empty_run  = '0;
            return w;
        end

        empty_run = '0;
        lim_x = coord_t'(((width_px == 0) ? 12'd1 : width_px) - 12'd1);
        lim_y = coord_t'(((height_px == 0) ? 12'd1 : height_px) - 12'd1);
        cx = (rx > lim_x) ? lim_x : rx;
        cy = (ry > lim_y) ? lim_y : ry;
        case (view)
            ORIENT_LANDSCAPE: begin
                ox = cy;
                oy = lim_x - cx;
            end
            ORIENT_PORTRAIT_FLIP: begin
                ox = lim_x - cx;
                oy = lim_y - cy;
            end
            ORIENT_LANDSCAPE_FLIP: begin
                ox = lim_y - cy;
                oy = cx;
            end
            default: begin
                ox = cx;
                oy = cy;
            end
        endcase
        w.flags.event_valid = 1'b1;
        w.ex = ox;
        w.ey = oy;

        if (!in_gesture) begin
            in_gesture = 1'b1;
            hold_done  = 1'b0;
            press_ms   = now;
            press_px   = ox;
            press_py   = oy;
            last_px    = ox;
            last_py    = oy;
            w.flags.is_start = 1'b1;
            return w;
        end

        last_px = ox;
        last_py = oy;
        w.flags.is_move = 1'b1;
        elapsed = now - press_ms;
        if (!hold_done && elapsed >= {16'd0, hold_limit_ms} && still_near()) begin
            hold_done = 1'b1;
            w.flags.is_hold = 1'b1;
        end
        return w;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            confirm_need  = RST_RELEASE_CONFIRM;
            tap_limit_ms  = RST_TAP_MAX_DUR;
            move_tol      = 12'(RST_TAP_TOLERANCE);
            hold_limit_ms = RST_HOLD_MS;
            width_px      = 12'(RST_SURFACE_WIDTH);
            height_px     = 12'(RST_SURFACE_HEIGHT);
            view          = ORIENT_PORTRAIT;
            in_gesture    = 1'b0;
            hold_done     = 1'b0;
            empty_run     = '0;
            press_ms      = '0;
            press_px      = '0;
            press_py      = '0;
            last_px       = '0;
            last_py       = '0;
            expected_events.delete();
            pending     <= 0;
            error_count <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.flags = evt_flags_t'(m_tuser);
                got.ex    = m_tdata[COORD_BITS-1:0];
                got.ey    = m_tdata[2*COORD_BITS-1:COORD_BITS];
                if (expected_events.size() == 0) begin
                    $display("%0t: ERROR event word with none expected: flags %b x %0d y %0d",
                             $realtime, got.flags, got.ex, got.ey);
                    error_count <= error_count + 1;
                end else begin
                    want = expected_events.pop_front();
                    if (got.flags.event_valid !== want.flags.event_valid ||
                        got.flags.is_start    !== want.flags.is_start ||
                        got.flags.is_move     !== want.flags.is_move ||
                        got.flags.is_hold     !== want.flags.is_hold ||
                        got.flags.is_release  !== want.flags.is_release ||
                        got.flags.is_tap      !== want.flags.is_tap ||
                        got.ex !== want.ex || got.ey !== want.ey) begin
                        $display("%0t: ERROR event mismatch: expected flags %b x %0d y %0d, got flags %b x %0d y %0d",
                                 $realtime, want.flags, want.ex, want.ey,
                                 got.flags, got.ex, got.ey);
                        error_count <= error_count + 1;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_RELEASE_CONFIRM: confirm_need  = cfg_data[7:0];
                    REG_TAP_MAX_DUR:     tap_limit_ms  = cfg_data;
                    REG_TAP_TOLERANCE:   move_tol      = cfg_data[11:0];
                    REG_HOLD_MS:         hold_limit_ms = cfg_data;
                    REG_SURFACE_WIDTH:   width_px      = cfg_data[11:0];
                    REG_SURFACE_HEIGHT:  height_px     = cfg_data[11:0];
                    REG_ORIENTATION:     view          = orient_t'(cfg_data[1:0]);
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_events.push_back(next_event(s_tuser,
                    s_tdata[COORD_BITS-1:0],
                    s_tdata[2*COORD_BITS-1:COORD_BITS],
                    s_tdata[2*COORD_BITS+TIME_W-1:2*COORD_BITS]));
            pending <= expected_events.size();
        end
    end

endmodule

/* tb/touch_gesture_recognizer_core_tb.sv */
`timescale 1ns / 1ps

module touch_gesture_recognizer_core_tb;

    localparam int COORD_BITS = 12;
    localparam int S_W        = ((2*COORD_BITS+tgr_pkg::TIME_W+7)/8)*8;
    localparam int M_W        = ((2*COORD_BITS+7)/8)*8;
    localparam int QUIET_LIMIT = 4000;
    localparam int LONG_HOLD   = 64;
    // No register lives at this index, so a write there must change nothing.
    localparam logic [tgr_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [S_W-1:0]                  s_tdata;
    logic                            s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [M_W-1:0]                  m_tdata;
    logic [5:0]                      m_tuser;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [tgr_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [tgr_pkg::CFG_DATA_W-1:0]  cfg_data;
    int                              error_count;
    int                              pending;

    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    bit          long_hold_req = 1'b0;
    int          cur_confirm, cur_tol, cur_width, cur_height, cur_step;
    logic [31:0] clock_ms;

    touch_gesture_recognizer_core #(.COORD_BITS(COORD_BITS)) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    touch_gesture_checker #(.COORD_BITS(COORD_BITS)) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .error_count (error_count),
        .pending     (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Result side: short random stalls, plus one long hold-off on request.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!aresetn) begin
                m_tready <= 1'b0;
            end else if (long_hold_req) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                long_hold_req = 1'b0;
                m_tready <= 1'b1;
            end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

    // Leaves s_tvalid high after the word is taken so that samples can run back to back.
    task automatic send_sample(input logic touched, input logic [11:0] rx,
                               input logic [11:0] ry, input logic [31:0] now);
        @(negedge aclk);
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= touched;
        s_tdata  <= {now, ry, rx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Stops offering samples and waits for every outstanding event word.
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [tgr_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [15:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic set_config(input logic [15:0] confirm, input logic [15:0] tap_ms,
                              input logic [15:0] tol, input logic [15:0] hold,
                              input logic [15:0] width, input logic [15:0] height,
                              input logic [15:0] view);
        int longest;
        drain();
        write_reg(tgr_pkg::REG_RELEASE_CONFIRM, confirm);
        write_reg(tgr_pkg::REG_TAP_MAX_DUR, tap_ms);
        write_reg(tgr_pkg::REG_TAP_TOLERANCE, tol);
        write_reg(tgr_pkg::REG_HOLD_MS, hold);
        write_reg(tgr_pkg::REG_SURFACE_WIDTH, width);
        write_reg(tgr_pkg::REG_SURFACE_HEIGHT, height);
        write_reg(tgr_pkg::REG_ORIENTATION, view);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        cur_confirm = confirm[7:0];
        cur_tol     = tol[11:0];
        cur_width   = width[11:0];
        cur_height  = height[11:0];
        longest     = (tap_ms > hold) ? tap_ms : hold;
        cur_step    = longest / 3 + 3;
    endtask

    function automatic logic [11:0] pick_coord(input int limit);
        return ($urandom_range(0, 1) == 0) ? 12'($urandom_range(0, limit))
                                          : 12'($urandom_range(0, 4095));
    endfunction

    // A position near the given one, within the current tolerance on each axis.
    function automatic logic [11:0] jitter(input int c);
        int v;
        v = c + int'($urandom_range(0, 2 * cur_tol)) - cur_tol;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return 12'(v);
    endfunction

    task automatic advance_clock();
        clock_ms = clock_ms + $urandom_range(0, cur_step);
    endtask

    // Mostly complete gestures (touch run, then enough empty samples to release) with
    // random content; the rest are stray samples that break the pattern.
    task automatic play_gestures(input int quota);
        int          counted, run, i, gaps;
        logic [11:0] bx, by;
        counted = 0;
        while (counted < quota) begin
            if ($urandom_range(0, 9) == 0) begin
                send_sample(1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)),
                            12'($urandom_range(0, 4095)), $urandom());
                counted++;
            end else begin
                if ($urandom_range(0, 7) == 0)
                    clock_ms = $urandom();
                bx  = pick_coord(cur_width);
                by  = pick_coord(cur_height);
                run = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 16)
                                                  : $urandom_range(1, 6);
                for (i = 0; i < run; i++) begin
                    if (i > 0 && cur_confirm > 1 && $urandom_range(0, 5) == 0) begin
                        gaps = $urandom_range(1, cur_confirm - 1);
                        repeat (gaps) begin
                            advance_clock();
                            send_sample(1'b0, 12'($urandom_range(0, 4095)),
                                        12'($urandom_range(0, 4095)), clock_ms);
                            counted++;
                        end
                    end
                    if ($urandom_range(0, 5) == 0) begin
                        bx = 12'($urandom_range(0, 4095));
                        by = 12'($urandom_range(0, 4095));
                    end
                    advance_clock();
                    send_sample(1'b1, jitter(bx), jitter(by), clock_ms);
                    counted++;
                end
                gaps = (cur_confirm == 0) ? 1 : cur_confirm;
                gaps += $urandom_range(0, 1);
                counted += gaps;
                repeat (gaps) begin
                    advance_clock();
                    send_sample(1'b0, 12'($urandom_range(0, 4095)),
                                12'($urandom_range(0, 4095)), clock_ms);
                end
            end
        end
    endtask

    initial begin
        int k;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        aresetn   = 1'b0;
        clock_ms  = 32'd0;
        cur_confirm = 2;
        cur_tol     = 12;
        cur_width   = 320;
        cur_height  = 480;
        cur_step    = 203;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings: an empty sample while idle, clamping at the top corner, a hold,
        // a long press, a tap after a short gap, a timestamp wrap, a move past the
        // tolerance and a timestamp that runs backward.
        send_sample(1'b0, 12'd0, 12'd0, 32'd0);
        send_sample(1'b1, 12'd4095, 12'd4095, 32'd1000);
        send_sample(1'b1, 12'd4095, 12'd4090, 32'd1100);
        send_sample(1'b1, 12'd319, 12'd479, 32'd1600);
        send_sample(1'b1, 12'd310, 12'd470, 32'd1700);
        send_sample(1'b0, 12'd0, 12'd0, 32'd1750);
        send_sample(1'b0, 12'd0, 12'd0, 32'd1800);
        send_sample(1'b1, 12'd0, 12'd0, 32'd5000);
        send_sample(1'b0, 12'd0, 12'd0, 32'd5050);
        send_sample(1'b1, 12'd5, 12'd5, 32'd5100);
        send_sample(1'b0, 12'd0, 12'd0, 32'd5120);
        send_sample(1'b0, 12'd0, 12'd0, 32'd5150);
        send_sample(1'b1, 12'd100, 12'd100, 32'hFFFF_FF00);
        send_sample(1'b1, 12'd100, 12'd100, 32'h0000_0100);
        send_sample(1'b1, 12'd112, 12'd88, 32'h0000_0200);
        send_sample(1'b0, 12'd0, 12'd0, 32'h0000_0210);
        send_sample(1'b0, 12'd0, 12'd0, 32'h0000_0220);
        send_sample(1'b1, 12'd200, 12'd200, 32'd10000);
        send_sample(1'b1, 12'd260, 12'd200, 32'd11000);
        send_sample(1'b1, 12'd200, 12'd200, 32'd5000);
        send_sample(1'b0, 12'd0, 12'd0, 32'd5001);
        send_sample(1'b0, 12'd0, 12'd0, 32'd5002);

        // All settings zero but a landscape view: a zero-sized surface and release on the first empty sample.
        set_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                   16'(tgr_pkg::ORIENT_LANDSCAPE));
        write_reg(REG_UNUSED, 16'($urandom()));
        @(negedge aclk);
        cfg_valid <= 1'b0;
        send_sample(1'b1, 12'd4095, 12'd123, 32'd0);
        send_sample(1'b0, 12'd0, 12'd0, 32'd0);
        play_gestures(60);

        // All ones on the bus; each register keeps only its own width. A release needs
        // 255 empty samples here, so one gesture is already a long run.
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        play_gestures(100);

        for (k = 3; k < 8; k++) begin
            set_config(16'($urandom_range(0, 4)), 16'($urandom_range(0, 1500)),
                       16'($urandom_range(0, 30)), 16'($urandom_range(0, 2500)),
                       16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 40)
                                                       : $urandom_range(1, 4095)),
                       16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 40)
                                                       : $urandom_range(1, 4095)),
                       16'(k % 4));
            if (k == 3)
                long_hold_req = 1'b1;
            if (k == 7) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            if (k == 4) begin
                play_gestures(20);
                drain();
                play_gestures(20);
            end else begin
                play_gestures(40);
            end
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (10) @(posedge aclk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
rtl/tgr_pkg.sv
rtl/tgr_orient.sv
rtl/touch_gesture_recognizer_core.sv
tb/touch_gesture_checker.sv
tb/touch_gesture_recognizer_core_tb.sv
